// File: hw/rtl/pdsp_pkg.sv
// types and constants shared by the date string parser
package pdsp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_t;

  typedef struct packed {
    logic        valid_res;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [1:0]  zone_relation;
    logic [4:0]  offset_hours;
    logic [5:0]  offset_minutes;
  } result_t;

  localparam logic [7:0] CHR_D     = 8'h44;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_Z     = 8'h5A;
  localparam logic [7:0] CHR_APOS  = 8'h27;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  localparam logic [1:0] ZONE_UNKNOWN = 2'd0;
  localparam logic [1:0] ZONE_BEHIND  = 2'd1;
  localparam logic [1:0] ZONE_AHEAD   = 2'd2;
  localparam logic [1:0] ZONE_EQUAL   = 2'd3;

  localparam logic [4:0] POS_ZONE   = 5'd14;
  localparam logic [4:0] POS_APOS_H = 5'd17;
  localparam logic [4:0] POS_APOS_M = 5'd20;
  localparam logic [4:0] BODY_MAX   = 5'd21;
  localparam logic [4:0] COUNT_MAX  = 5'd31;
  localparam logic [4:0] MIN_TOTAL  = 5'd4;

  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] DAY_MAX    = 7'd31;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;

endpackage

// File: hw/rtl/pdf_date_string_parser.sv
// Date string parser: one character per clock while char_stall is low, one result per string
//
// Takes a date string [D:]YYYY[MM[DD[HH[mm[SS[O[HH'[mm']]]]]]]] one byte per
// transaction, with last_char set on the final byte. With each accepted byte a
// position counter and a set of decimal accumulators advance, and the length
// and range checks are made in the same cycle as the final byte, so a new
// character is accepted on every clock while char_stall is low. One result
// per string leaves from an output register; a second register behind it lets
// the input keep running while a result waits, and char_stall rises only when
// both hold results. Missing fields read month 1, day 1 and zero elsewhere;
// on any error valid_res is 0 and all fields are 0.
module pdf_date_string_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_valid,
  output logic             char_stall,
  input  pdsp_pkg::char_t  char_data,
  output logic             res_valid,
  input  logic             res_stall,
  output pdsp_pkg::result_t res_data
);
  import pdsp_pkg::*;

  logic [4:0]  char_count, char_count_next;
  logic        marker_present, marker_present_next;
  logic        first_is_d, first_is_d_next;
  logic [13:0] year_acc, year_acc_next;
  logic [6:0]  month_acc, month_acc_next;
  logic [6:0]  day_acc, day_acc_next;
  logic [6:0]  hour_acc, hour_acc_next;
  logic [6:0]  minute_acc, minute_acc_next;
  logic [6:0]  second_acc, second_acc_next;
  logic [1:0]  zone_code, zone_code_next;
  logic [6:0]  offset_hour_acc, offset_hour_acc_next;
  logic [6:0]  offset_minute_acc, offset_minute_acc_next;
  logic        syntax_error, syntax_error_next;

  logic        skid_valid;
  result_t     skid_data;
  result_t     result;

  logic        accept;
  logic        res_new;
  logic [7:0]  c;
  logic        is_digit;
  logic [3:0]  digit;
  logic [4:0]  bpos;
  logic [4:0]  body;
  logic        ok;

  function automatic logic [6:0] add_digit7(input logic [6:0] acc, input logic [3:0] d);
    logic [6:0] t;
    t = {acc[3:0], 3'b000} + {acc[5:0], 1'b0} + {3'b000, d};
    return t;
  endfunction

  function automatic logic [13:0] add_digit14(input logic [13:0] acc, input logic [3:0] d);
    logic [13:0] t;
    t = {acc[10:0], 3'b000} + {acc[12:0], 1'b0} + {10'd0, d};
    return t;
  endfunction

  assign accept     = char_valid && !char_stall;
  assign res_new    = accept && char_data.last_char;
  assign char_stall = skid_valid;

  always_comb begin
    c         = char_data.char_code;
    is_digit  = (c >= CHR_ZERO) && (c <= CHR_NINE);
    digit     = is_digit ? c[3:0] : 4'd0;
    bpos      = marker_present ? char_count - 5'd2 : char_count;

    marker_present_next    = marker_present;
    first_is_d_next        = first_is_d;
    year_acc_next          = year_acc;
    month_acc_next         = month_acc;
    day_acc_next           = day_acc;
    hour_acc_next          = hour_acc;
    minute_acc_next        = minute_acc;
    second_acc_next        = second_acc;
    zone_code_next         = zone_code;
    offset_hour_acc_next   = offset_hour_acc;
    offset_minute_acc_next = offset_minute_acc;
    syntax_error_next      = syntax_error;

    if (char_count == 5'd0 && c == CHR_D) begin
      first_is_d_next = 1'b1;
    end else if (char_count == 5'd1 && first_is_d) begin
      if (c == CHR_COLON) marker_present_next = 1'b1;
      else syntax_error_next = 1'b1;
    end else if (bpos < BODY_MAX) begin
      if (bpos == POS_ZONE) begin
        case (c)
          CHR_PLUS:  zone_code_next = ZONE_AHEAD;
          CHR_MINUS: zone_code_next = ZONE_BEHIND;
          CHR_Z:     zone_code_next = ZONE_EQUAL;
          default:   syntax_error_next = 1'b1;
        endcase
      end else if (bpos == POS_APOS_H || bpos == POS_APOS_M) begin
        if (c != CHR_APOS) syntax_error_next = 1'b1;
      end else if (!is_digit) begin
        syntax_error_next = 1'b1;
      end else begin
        case (bpos) inside
          [5'd0:5'd3]:   year_acc_next = add_digit14(year_acc, digit);
          [5'd4:5'd5]:   month_acc_next = add_digit7(month_acc, digit);
          [5'd6:5'd7]:   day_acc_next = add_digit7(day_acc, digit);
          [5'd8:5'd9]:   hour_acc_next = add_digit7(hour_acc, digit);
          [5'd10:5'd11]: minute_acc_next = add_digit7(minute_acc, digit);
          [5'd12:5'd13]: second_acc_next = add_digit7(second_acc, digit);
          [5'd15:5'd16]: offset_hour_acc_next = add_digit7(offset_hour_acc, digit);
          default:       offset_minute_acc_next = add_digit7(offset_minute_acc, digit);
        endcase
      end
    end

    char_count_next = (char_count < COUNT_MAX) ? char_count + 5'd1 : COUNT_MAX;
  end

  // final checks on the state as it stands after this byte
  always_comb begin
    body = marker_present_next ? char_count_next - 5'd2 : char_count_next;
    ok = (char_count_next >= MIN_TOTAL) && !syntax_error_next;
    case (body) inside
      5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14, 5'd15, 5'd18, 5'd21: ;
      default: ok = 1'b0;
    endcase
    if (body >= 5'd6 && (month_acc_next < 7'd1 || month_acc_next > MONTH_MAX)) ok = 1'b0;
    if (body >= 5'd8 && (day_acc_next < 7'd1 || day_acc_next > DAY_MAX)) ok = 1'b0;
    if (body >= 5'd10 && hour_acc_next > HOUR_MAX) ok = 1'b0;
    if (body >= 5'd12 && minute_acc_next > MINSEC_MAX) ok = 1'b0;
    if (body >= 5'd14 && second_acc_next > MINSEC_MAX) ok = 1'b0;
    if (body >= 5'd18 && offset_hour_acc_next > HOUR_MAX) ok = 1'b0;
    if (body >= 5'd21 && offset_minute_acc_next > MINSEC_MAX) ok = 1'b0;

    result = '0;
    if (ok) begin
      result.valid_res      = 1'b1;
      result.year           = year_acc_next;
      result.month          = (body >= 5'd6) ? month_acc_next[3:0] : 4'd1;
      result.day            = (body >= 5'd8) ? day_acc_next[4:0] : 5'd1;
      result.hour           = (body >= 5'd10) ? hour_acc_next[4:0] : 5'd0;
      result.minute         = (body >= 5'd12) ? minute_acc_next[5:0] : 6'd0;
      result.second         = (body >= 5'd14) ? second_acc_next[5:0] : 6'd0;
      result.zone_relation  = (body >= 5'd15) ? zone_code_next : ZONE_UNKNOWN;
      result.offset_hours   = (body >= 5'd18) ? offset_hour_acc_next[4:0] : 5'd0;
      result.offset_minutes = (body >= 5'd21) ? offset_minute_acc_next[5:0] : 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || res_new) begin
      char_count        <= '0;
      marker_present    <= 1'b0;
      first_is_d        <= 1'b0;
      year_acc          <= '0;
      month_acc         <= '0;
      day_acc           <= '0;
      hour_acc          <= '0;
      minute_acc        <= '0;
      second_acc        <= '0;
      zone_code         <= ZONE_UNKNOWN;
      offset_hour_acc   <= '0;
      offset_minute_acc <= '0;
      syntax_error      <= 1'b0;
    end else if (accept) begin
      char_count        <= char_count_next;
      marker_present    <= marker_present_next;
      first_is_d        <= first_is_d_next;
      year_acc          <= year_acc_next;
      month_acc         <= month_acc_next;
      day_acc           <= day_acc_next;
      hour_acc          <= hour_acc_next;
      minute_acc        <= minute_acc_next;
      second_acc        <= second_acc_next;
      zone_code         <= zone_code_next;
      offset_hour_acc   <= offset_hour_acc_next;
      offset_minute_acc <= offset_minute_acc_next;
      syntax_error      <= syntax_error_next;
    end
  end

  // output register with a skid slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= res_new;
      end
    end else if (res_new) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      if (skid_valid) res_data <= skid_data;
      else if (res_new) res_data <= result;
    end else if (res_new) begin
      skid_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid slot holds a result while the output register is empty");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    res_new |=> char_count == 5'd0 && !marker_present && !syntax_error)
    else $error("string state not cleared after the final byte");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.valid_res |-> res_data.year == 14'd0 &&
      res_data.month == 4'd0 && res_data.day == 5'd0 &&
      res_data.zone_relation == ZONE_UNKNOWN)
    else $error("failed result carries nonzero fields");

  a_good_ranges: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.valid_res |-> res_data.month >= 4'd1 &&
      res_data.month <= 4'd12 && res_data.day >= 5'd1 && res_data.hour <= 5'd23)
    else $error("valid result out of range");
`endif

endmodule
